@@ hdl/fbq_pkg.sv @@
package fbq_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] addr;
    } blk_t;

    // per-cycle command broadcast to every cell
    typedef struct packed
    {
        logic ins;
        logic rem;
        blk_t blk;
    } cmd_t;

    // a ranks strictly above b: larger size, then lower address
    function automatic logic ranks_above(input blk_t a, input blk_t b);
        logic res;
        if (a.size != b.size)
        begin
            res = (a.size > b.size);
        end
        else
        begin
            res = (a.addr < b.addr);
        end
        return res;
    endfunction

endpackage

@@ hdl/fbq_cell.sv @@
module fbq_cell
(
    input  logic          clk,
    input  fbq_pkg::cmd_t cmd,
    input  logic          occ,
    input  fbq_pkg::blk_t prev_blk,
    input  logic          prev_above,
    input  fbq_pkg::blk_t next_blk,
    output fbq_pkg::blk_t blk,
    output logic          above
);
    import fbq_pkg::*;

    blk_t blk_reg;
    blk_t blk_next;

    // an empty cell always yields to the new block
    assign above = !occ || ranks_above(cmd.blk, blk_reg);
    assign blk   = blk_reg;

    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.ins)
        begin
            if (prev_above)
            begin
                blk_next = prev_blk;
            end
            else if (above)
            begin
                blk_next = cmd.blk;
            end
        end
        else if (cmd.rem)
        begin
            blk_next = next_blk;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

@@ hdl/free_block_max_priority_queue_unit.sv @@
// free block max priority queue
// command channel: drive op, block_size and block_addr with start high; the
// transaction is taken at the rising edge where start is high and busy is low.
// op insert stores a block, op remove takes out the top block (largest size,
// lowest address on equal size) and returns it.
// result channel: done is high for exactly one cycle, the cycle after the
// command is taken; found, out_size, out_addr, overflow, is_empty, top_size
// and occupancy are valid in that cycle and the receiver cannot stall them.
// the block takes no new command during the result cycle: the sorted cell
// chain shifts in the cycle the command is taken, and busy stays high
// during the result cycle.
// an insert into a full queue is dropped and reports overflow; a remove from
// an empty queue reports found low with zero size and address.
// reset clears the occupancy count and the result strobe; the queue is empty
// after reset and a command may be issued in the first cycle after it.
module free_block_max_priority_queue_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  fbq_pkg::op_t                op,
    input  logic [31:0]                 block_size,
    input  logic [31:0]                 block_addr,
    output logic                        done,
    output logic                        found,
    output logic [31:0]                 out_size,
    output logic [31:0]                 out_addr,
    output logic                        overflow,
    output logic                        is_empty,
    output logic [31:0]                 top_size,
    output logic [fbq_pkg::CNT_W-1:0]   occupancy
);
    import fbq_pkg::*;

    logic             done_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             found_reg;
    logic             ovf_reg;
    blk_t             out_reg;

    logic accept;
    logic full;
    logic has_top;
    cmd_t cmd;

    blk_t cell_blk   [CAPACITY];
    logic cell_above [CAPACITY];
    logic cell_occ   [CAPACITY];

    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign has_top = (count_reg != '0);

    assign cmd.ins      = accept && (op == OP_INSERT) && !full;
    assign cmd.rem      = accept && (op == OP_REMOVE) && has_top;
    assign cmd.blk.size = block_size;
    assign cmd.blk.addr = block_addr;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            blk_t prev_blk;
            logic prev_above;
            blk_t next_blk;

            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign prev_blk   = cmd.blk;
                assign prev_above = 1'b0;
            end
            else
            begin : g_body
                assign prev_blk   = cell_blk[gi-1];
                assign prev_above = cell_above[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign next_blk = cmd.blk;
            end
            else
            begin : g_mid
                assign next_blk = cell_blk[gi+1];
            end

            fbq_cell u_cell
            (
                .clk        (clk),
                .cmd        (cmd),
                .occ        (cell_occ[gi]),
                .prev_blk   (prev_blk),
                .prev_above (prev_above),
                .next_blk   (next_blk),
                .blk        (cell_blk[gi]),
                .above      (cell_above[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg  <= accept;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg <= cmd.rem;
            ovf_reg   <= (op == OP_INSERT) && full;
            out_reg   <= cmd.rem ? cell_blk[0] : '0;
        end
    end

    assign busy      = done_reg;
    assign done      = done_reg;
    assign found     = found_reg;
    assign out_size  = out_reg.size;
    assign out_addr  = out_reg.addr;
    assign overflow  = ovf_reg;
    assign is_empty  = !has_top;
    assign top_size  = has_top ? cell_blk[0].size : '0;
    assign occupancy = count_reg;

endmodule

@@ hdl/fbq_checker.sv @@
module fbq_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input fbq_pkg::op_t              op,
    input logic                      done,
    input logic                      found,
    input logic                      overflow,
    input logic                      is_empty,
    input logic [fbq_pkg::CNT_W-1:0] occupancy
);
    import fbq_pkg::*;

    // every taken transaction gets its result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done)
    else $error("no result after taken transaction");

    // remove from an empty queue never returns a block
    a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == OP_REMOVE) && (occupancy == '0) |=> done && !found)
    else $error("block returned from empty queue");

    // overflow only when the queue was full before the insert
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> (occupancy == CNT_W'(CAPACITY)) && !found)
    else $error("overflow without full queue");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (occupancy == '0)))
    else $error("empty flag disagrees with occupancy");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

endmodule

bind free_block_max_priority_queue_unit fbq_checker u_fbq_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .done      (done),
    .found     (found),
    .overflow  (overflow),
    .is_empty  (is_empty),
    .occupancy (occupancy)
);

@@ test/tb_free_block_max_priority_queue_unit.sv @@
module tb_free_block_max_priority_queue_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fbq_pkg::*;

    localparam int RANDOM_ITEMS = 815;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed
    {
        logic               found;
        logic [31:0]        out_size;
        logic [31:0]        out_addr;
        logic               overflow;
        logic               is_empty;
        logic [31:0]        top_size;
        logic [CNT_W-1:0]   occupancy;
    } result_t;

    typedef struct
    {
        op_t         op;
        logic [31:0] size;
        logic [31:0] addr;
        int          rep;
        bit          typed;
        result_t     want;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    op_t                op = OP_INSERT;
    logic [31:0]        block_size = '0;
    logic [31:0]        block_addr = '0;
    logic               busy;
    logic               done;
    logic               found;
    logic [31:0]        out_size;
    logic [31:0]        out_addr;
    logic               overflow;
    logic               is_empty;
    logic [31:0]        top_size;
    logic [CNT_W-1:0]   occupancy;

    // hand-written expectation that rides along with the transaction
    bit                 typed_flag = 1'b0;
    result_t            typed_want = '0;

    // shadow copy of the queue contents, kept in storage order
    logic [31:0]        shadow_size [CAPACITY];
    logic [31:0]        shadow_addr [CAPACITY];
    int                 shadow_count = 0;

    result_t            pending_results [$];
    row_t               script [$];
    int                 err_count = 0;
    int                 result_count = 0;
    int                 n_insert = 0;
    int                 n_dropped = 0;
    int                 n_remove = 0;
    int                 n_miss = 0;
    int                 peak_occupancy = 0;

    free_block_max_priority_queue_unit dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .block_size (block_size),
        .block_addr (block_addr),
        .done       (done),
        .found      (found),
        .out_size   (out_size),
        .out_addr   (out_addr),
        .overflow   (overflow),
        .is_empty   (is_empty),
        .top_size   (top_size),
        .occupancy  (occupancy)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit outranks(logic [31:0] sa, logic [31:0] aa,
                                    logic [31:0] sb, logic [31:0] ab);
        if (sa != sb)
        begin
            return sa > sb;
        end
        return aa < ab;
    endfunction

    // first entry in storage order wins a full tie
    function automatic int best_slot();
        int best;
        best = 0;
        for (int i = 1; i < shadow_count; i++)
        begin
            if (outranks(shadow_size[i], shadow_addr[i], shadow_size[best], shadow_addr[best]))
            begin
                best = i;
            end
        end
        return best;
    endfunction

    function automatic result_t queue_step(op_t o, logic [31:0] s, logic [31:0] a);
        result_t r;
        int      t;
        r = '0;
        if (o == OP_INSERT)
        begin
            if (shadow_count >= CAPACITY)
            begin
                r.overflow = 1'b1;
            end
            else
            begin
                shadow_size[shadow_count] = s;
                shadow_addr[shadow_count] = a;
                shadow_count++;
            end
        end
        else if (shadow_count > 0)
        begin
            t = best_slot();
            r.found    = 1'b1;
            r.out_size = shadow_size[t];
            r.out_addr = shadow_addr[t];
            for (int i = t; i < shadow_count - 1; i++)
            begin
                shadow_size[i] = shadow_size[i + 1];
                shadow_addr[i] = shadow_addr[i + 1];
            end
            shadow_count--;
        end
        r.is_empty  = (shadow_count == 0);
        r.top_size  = (shadow_count == 0) ? 32'h0 : shadow_size[best_slot()];
        r.occupancy = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= MAX_PRINTS)
        begin
            $display("[%0t] result %0d: %s", $realtime, result_count, msg);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                got = '{found, out_size, out_addr, overflow, is_empty, top_size, occupancy};
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result strobe with no transaction outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b", got.found, want.found));
                    if (got.out_size !== want.out_size)
                        report_mismatch($sformatf("out_size %h, want %h",
                                                  got.out_size, want.out_size));
                    if (got.out_addr !== want.out_addr)
                        report_mismatch($sformatf("out_addr %h, want %h",
                                                  got.out_addr, want.out_addr));
                    if (got.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %0b, want %0b",
                                                  got.overflow, want.overflow));
                    if (got.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %0b, want %0b",
                                                  got.is_empty, want.is_empty));
                    if (got.top_size !== want.top_size)
                        report_mismatch($sformatf("top_size %h, want %h",
                                                  got.top_size, want.top_size));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, want %0d",
                                                  got.occupancy, want.occupancy));
                end
                result_count++;
            end
            if (start && !busy)
            begin
                want = queue_step(op, block_size, block_addr);
                if (op == OP_INSERT)
                begin
                    n_insert++;
                    n_dropped += want.overflow;
                end
                else
                begin
                    n_remove++;
                    n_miss += !want.found;
                end
                if (shadow_count > peak_occupancy)
                    peak_occupancy = shadow_count;
                if (typed_flag)
                    want = typed_want;
                pending_results.push_back(want);
            end
        end
    end

    // start stays high across back-to-back transactions
    task automatic send_request(op_t o, logic [31:0] s, logic [31:0] a,
                                bit typed, result_t want, bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        op         <= o;
        block_size <= s;
        block_addr <= a;
        typed_flag <= typed;
        typed_want <= want;
        do @(posedge clk); while (busy);
    endtask

    task automatic add_row(op_t o, logic [31:0] s, logic [31:0] a, int rep,
                           bit typed, result_t want);
        row_t r;
        r.op    = o;
        r.size  = s;
        r.addr  = a;
        r.rep   = rep;
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endtask

    function automatic logic [31:0] draw_word();
        logic [31:0] w;
        case ($urandom_range(3))
            0: w = $urandom_range(15);
            1: w = $urandom;
            2: w = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : $urandom_range(3);
            default: w = $urandom & 32'hFFFF_0F0F;
        endcase
        return w;
    endfunction

    initial
    begin : stimulus
        int   sent;
        int   burst;
        int   ins_pct;
        int   mode;
        bit   calm;
        op_t  o;

        // remove on empty, both field extremes, ties on size and address,
        // overflow on a full queue, and a full drain
        add_row(OP_REMOVE, 32'h0, 32'h0, 1, 1'b1,
                '{1'b0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, 9'd0});
        add_row(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 1, 1'b1,
                '{1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 32'hFFFF_FFFF, 9'd1});
        add_row(OP_REMOVE, 32'h0, 32'h0, 1, 1'b1,
                '{1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 32'h0, 9'd0});
        add_row(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 1, 1'b1,
                '{1'b0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 9'd1});
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
                '{1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0, 9'd0});
        add_row(OP_INSERT, 32'd5, 32'd100, 1, 1'b0, '0);
        add_row(OP_INSERT, 32'd5, 32'd50, 1, 1'b0, '0);
        add_row(OP_INSERT, 32'd5, 32'd50, 1, 1'b0, '0);
        add_row(OP_INSERT, 32'd7, 32'd200, 1, 1'b0, '0);
        add_row(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1, 1'b0, '0);
        add_row(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1, 1'b0, '0);
        add_row(OP_REMOVE, 32'h0, 32'h0, 7, 1'b0, '0);
        add_row(OP_INSERT, 32'h1000, 32'h0, CAPACITY, 1'b0, '0);
        add_row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
                '{1'b0, 32'h0, 32'h0, 1'b1, 1'b0, 32'h1000, 9'd256});
        add_row(OP_REMOVE, 32'h0, 32'h0, 1, 1'b1,
                '{1'b1, 32'h1000, 32'h0, 1'b0, 1'b0, 32'h1000, 9'd255});
        add_row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, '0);
        add_row(OP_REMOVE, 32'h0, 32'h0, CAPACITY + 1, 1'b0, '0);
        add_row(OP_REMOVE, 32'h0, 32'h0, 1, 1'b1,
                '{1'b0, 32'h0, 32'h0, 1'b0, 1'b1, 32'h0, 9'd0});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[r])
        begin
            for (int i = 0; i < script[r].rep; i++)
            begin
                send_request(script[r].op, script[r].size, script[r].addr + i,
                             script[r].typed, script[r].want, 1'b0);
            end
        end

        // bursts that lean toward filling, draining or mixing the queue
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode = $urandom_range(2);
            calm = ($urandom_range(3) == 0);
            case (mode)
                0:
                begin
                    burst   = $urandom_range(10, 60);
                    ins_pct = 50;
                end
                1:
                begin
                    burst   = $urandom_range(60, 300);
                    ins_pct = 85;
                end
                default:
                begin
                    burst   = $urandom_range(60, 300);
                    ins_pct = 15;
                end
            endcase
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++)
            begin
                o = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
                send_request(o, draw_word(), draw_word(), 1'b0, '0, calm);
                sent++;
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d transactions: %0d inserts (%0d dropped on full), %0d removes (%0d on empty)",
                 n_insert + n_remove, n_insert, n_dropped, n_remove, n_miss);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_occupancy, CAPACITY,
                 err_count);
        if (err_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/fbq_pkg.sv
hdl/fbq_cell.sv
hdl/free_block_max_priority_queue_unit.sv
hdl/fbq_checker.sv
test/tb_free_block_max_priority_queue_unit.sv
